// ===== src/abss_pkg.sv =====
// ----------------------------------------------------------------------------
// abss_pkg: shared types and constants of the A/B boot slot selector
// Record layout, decision and action codes, and the state and result
// structs passed between the step logic and the core.
// ----------------------------------------------------------------------------
package abss_pkg;

    localparam int SLOT_COUNT = 512;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int WORD_W     = 26;
    localparam int ATTEMPT_W  = 4;

    localparam logic [15:0]          MAGIC_WORD    = 16'h4A57;
    localparam logic [ATTEMPT_W-1:0] ATTEMPT_LIMIT = 4'd3;
    localparam logic [SLOT_W-1:0]    SLOT_LAST     = SLOT_W'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ACT_BOOT    = 3'd0,
        ACT_CONFIRM = 3'd1,
        ACT_REQUEST = 3'd2,
        ACT_COMMIT  = 3'd3,
        ACT_CLEAR   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        DEC_NONE   = 3'd0,
        DEC_JUMP   = 3'd1,
        DEC_RESET  = 3'd2,
        DEC_LOADER = 3'd3,
        DEC_HALT   = 3'd4
    } decision_t;

    typedef struct packed {
        logic                 present;
        logic                 image;
        logic                 a_valid;
        logic                 b_valid;
        logic                 requested;
        logic                 running;
        logic [ATTEMPT_W-1:0] attempt;
        logic [SLOT_W-1:0]    slot;
    } abss_state_t;

    typedef struct packed {
        decision_t         decision;
        logic              image;
        logic              written;
        logic              erase;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
    } abss_result_t;

    localparam abss_state_t STATE_RESET = '{
        present:   1'b0,
        image:     1'b0,
        a_valid:   1'b0,
        b_valid:   1'b0,
        requested: 1'b0,
        running:   1'b0,
        attempt:   ATTEMPT_W'(1),
        slot:      '0
    };

    function automatic logic [WORD_W-1:0] pack_record(abss_state_t s);
        return {s.running, s.attempt, s.b_valid, 1'b0, s.a_valid,
                s.requested, s.image, MAGIC_WORD};
    endfunction

endpackage

// ===== src/ab_boot_slot_selector_core.sv =====
// ----------------------------------------------------------------------------
// ab_boot_slot_selector_core: A/B boot control record with attempt counter
// Output: the result of each input transfer is registered in the output register.
// Throughput: one event per cycle while the input is not stalled; the record state updates in the same edge.
// The input stalls only while a result waits and the output is stalled.
// Reset: record cleared (image A, both invalid, attempt 1, ring slot 0).
// ----------------------------------------------------------------------------
module ab_boot_slot_selector_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  action,
    input  logic                        safety_reset,
    input  logic                        next_image,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  decision,
    output logic                        boot_image,
    output logic                        record_written,
    output logic                        erase_first,
    output logic [abss_pkg::SLOT_W-1:0] write_slot,
    output logic [abss_pkg::WORD_W-1:0] record_word
);
    import abss_pkg::*;

    abss_state_t  state_reg;
    abss_state_t  state_next;
    abss_result_t step_res;
    abss_result_t res_reg;
    logic         out_valid_reg;
    logic         accept;

    abss_step u_step (
        .cur          (state_reg),
        .action       (action),
        .safety_reset (safety_reset),
        .next_image   (next_image),
        .nxt          (state_next),
        .res          (step_res)
    );

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result while the output is stalled
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= step_res;
    end

    assign out_valid      = out_valid_reg;
    assign decision       = res_reg.decision;
    assign boot_image     = res_reg.image;
    assign record_written = res_reg.written;
    assign erase_first    = res_reg.erase;
    assign write_slot     = res_reg.slot;
    assign record_word    = res_reg.word;

    a_magic: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_written |-> record_word[15:0] == MAGIC_WORD)
        else $error("written record lacks magic");

    a_erase_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_written && erase_first |-> write_slot == '0)
        else $error("erase on a slot other than zero");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && decision == DEC_HALT |-> !record_written)
        else $error("halt wrote a record");

    a_empty_ring: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.present |-> state_reg.slot == '0)
        else $error("ring head moved without a record");

    a_write_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept && step_res.written |=> state_reg.present)
        else $error("record not marked present after write");

endmodule

// ===== src/abss_step.sv =====
// ----------------------------------------------------------------------------
// abss_step: next-state and result logic for one event
// Decides the boot action, updates the control record and forms the
// ring write for a single event. Purely combinational.
// ----------------------------------------------------------------------------
module abss_step (
    input  abss_pkg::abss_state_t  cur,
    input  logic [2:0]             action,
    input  logic                   safety_reset,
    input  logic                   next_image,
    output abss_pkg::abss_state_t  nxt,
    output abss_pkg::abss_result_t res
);
    import abss_pkg::*;

    always_comb
    begin
        logic        do_write;
        logic        cur_valid;
        logic        keep_a;
        logic        keep_b;
        abss_state_t st;

        do_write  = 1'b0;
        st        = cur;
        cur_valid = cur.image ? cur.b_valid : cur.a_valid;
        keep_a    = cur.image ? cur.a_valid : 1'b0;
        keep_b    = cur.image ? 1'b0 : cur.b_valid;

        res          = '0;
        res.decision = DEC_NONE;

        unique case (action)
            ACT_BOOT:
            begin
                priority if (!cur.present)
                begin
                    st           = STATE_RESET;
                    do_write     = 1'b1;
                    res.decision = DEC_RESET;
                end
                else if (cur.requested && cur.running)
                begin
                    // rollback: the new image never confirmed
                    st.running   = 1'b0;
                    st.requested = 1'b0;
                    st.attempt   = ATTEMPT_W'(1);
                    do_write     = 1'b1;
                    res.decision = DEC_JUMP;
                end
                else if (cur.requested)
                begin
                    st.running   = 1'b1;
                    do_write     = 1'b1;
                    res.decision = DEC_LOADER;
                end
                else if (cur_valid && cur.attempt == '0)
                begin
                    res.decision = DEC_JUMP;
                end
                else if (safety_reset && cur.attempt >= ATTEMPT_LIMIT)
                begin
                    // drop the failing image, fall back if the other is good
                    if (keep_a || keep_b)
                    begin
                        st.a_valid   = keep_a;
                        st.b_valid   = keep_b;
                        st.image     = !keep_a;
                        st.attempt   = ATTEMPT_W'(1);
                        do_write     = 1'b1;
                        res.decision = DEC_JUMP;
                    end
                    else
                    begin
                        res.decision = DEC_HALT;
                    end
                end
                else if (safety_reset)
                begin
                    st.attempt   = cur.attempt + ATTEMPT_W'(1);
                    do_write     = 1'b1;
                    res.decision = DEC_JUMP;
                end
                else
                begin
                    st.attempt   = ATTEMPT_W'(1);
                    do_write     = 1'b1;
                    res.decision = DEC_JUMP;
                end
            end
            ACT_CONFIRM:
            begin
                priority if (!cur.present)
                begin
                    st           = STATE_RESET;
                    do_write     = 1'b1;
                    res.decision = DEC_RESET;
                end
                else if (cur.attempt != '0)
                begin
                    if (cur.image)
                        st.b_valid = 1'b1;
                    else
                        st.a_valid = 1'b1;
                    st.requested = 1'b0;
                    st.attempt   = '0;
                    do_write     = 1'b1;
                end
                else
                begin
                    res.decision = DEC_NONE;
                end
            end
            ACT_REQUEST:
            begin
                st.requested = 1'b1;
                st.running   = 1'b0;
                do_write     = 1'b1;
                res.decision = DEC_RESET;
            end
            ACT_COMMIT:
            begin
                if (next_image)
                    st.b_valid = 1'b0;
                else
                    st.a_valid = 1'b0;
                st.image     = next_image;
                st.requested = 1'b0;
                st.running   = 1'b0;
                st.attempt   = ATTEMPT_W'(1);
                do_write     = 1'b1;
            end
            ACT_CLEAR:
            begin
                st        = STATE_RESET;
                res.erase = 1'b1;
            end
            default:
            begin
                st = cur;
            end
        endcase

        // append the record at the ring head and advance
        if (do_write)
        begin
            res.written = 1'b1;
            res.erase   = (st.slot == '0);
            res.slot    = st.slot;
            res.word    = pack_record(st);
            st.slot     = (st.slot == SLOT_LAST) ? '0 : st.slot + SLOT_W'(1);
            st.present  = 1'b1;
        end

        res.image = st.image;
        nxt       = st;
    end

endmodule
